### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used by the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define CS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define CS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cs_pkg.sv
// ---------------------------------------------------------------------------
// Counting sorter package
// Payload types of the input and result channels.
// ---------------------------------------------------------------------------
package cs_pkg;

  localparam int KEY_W = 8;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             is_last;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_value;
    logic             last_out;
  } out_t;

endpackage

### sv/counting_sorter.sv
// Load: a key is taken in S_IDLE, which reads its histogram bin, and S_INC
// writes the bin back incremented; keys beyond MAX_ITEMS are not counted.
// Emission: S_RD reads a bin, S_CHK checks and clears it, and S_OUT gives one
// result per count while the output is free; the walk ends at the largest key.
// Reset clears control state, then a clearing pass over all min(KEY_BINS,256)
// bins zeroes the histogram while no input transaction is taken.
// ---------------------------------------------------------------------------
// Counting sorter
// Histogram based sort of 8-bit keys, walked in ascending order on the last key.
// ---------------------------------------------------------------------------
module counting_sorter #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BINS  = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cs_pkg::in_t    in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cs_pkg::out_t   out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [cs_pkg::KEY_W-1:0] cfg_data
);

  localparam int NBINS  = (KEY_BINS < 256) ? KEY_BINS : 256;
  localparam int BW     = $clog2(NBINS);
  localparam int ITEM_W = $clog2(MAX_ITEMS + 1);
  localparam logic [cs_pkg::KEY_W-1:0] TOP_KEY = cs_pkg::KEY_W'(NBINS - 1);
  localparam logic [BW-1:0] BIN_TOP = BW'(NBINS - 1);
  localparam logic [ITEM_W-1:0] FULL_CNT = ITEM_W'(MAX_ITEMS);
  localparam logic [ITEM_W-1:0] ONE_CNT = ITEM_W'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [ITEM_W-1:0]       items_r, items_nxt;
  logic [BW-1:0]           bin_r, bin_nxt;
  logic [ITEM_W-1:0]       cnt_r, cnt_nxt;
  logic [BW-1:0]           key_r, key_nxt;
  logic                    last_r, last_nxt;
  logic [cs_pkg::KEY_W-1:0] max_r;
  logic                    out_valid_r, out_valid_nxt;
  cs_pkg::out_t            out_data_r, out_data_nxt;

  logic [ITEM_W-1:0]       mem [NBINS];
  logic [ITEM_W-1:0]       rd_data_r;
  logic                    we;
  logic [BW-1:0]           wa;
  logic [ITEM_W-1:0]       wd;
  logic [BW-1:0]           ra;

  logic [cs_pkg::KEY_W-1:0] key_c;
  logic [cs_pkg::KEY_W-1:0] key_b;
  logic [BW-1:0]            key_idx;
  logic                     out_free;

  assign key_c    = (in_data.key_value > max_r) ? max_r : in_data.key_value;
  assign key_b    = (key_c > TOP_KEY) ? TOP_KEY : key_c;
  assign key_idx  = key_b[BW-1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    items_nxt     = items_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    wa            = bin_r;
    wd            = '0;
    ra            = bin_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (bin_r == BIN_TOP) begin
          bin_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          bin_nxt = bin_r + 1'b1;
        end
      end
      S_IDLE: begin
        ra = key_idx;
        if (in_valid) begin
          key_nxt  = key_idx;
          last_nxt = in_data.is_last;
          if (items_r != FULL_CNT) begin
            state_nxt = S_INC;
          end else if (in_data.is_last) begin
            bin_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_INC: begin
        we        = 1'b1;
        wa        = key_r;
        wd        = rd_data_r + 1'b1;
        items_nxt = items_r + 1'b1;
        if (last_r) begin
          bin_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = rd_data_r;
        if (rd_data_r != '0) begin
          we        = 1'b1;
          state_nxt = S_OUT;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = cs_pkg::KEY_W'(bin_r);
          out_data_nxt.last_out     = (items_r == ONE_CNT);
          items_nxt                 = items_r - 1'b1;
          cnt_nxt                   = cnt_r - 1'b1;
          if (cnt_r == ONE_CNT) begin
            if (items_r == ONE_CNT) begin
              bin_nxt   = '0;
              state_nxt = S_IDLE;
            end else begin
              bin_nxt   = bin_r + 1'b1;
              state_nxt = S_RD;
            end
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      items_r     <= '0;
      bin_r       <= '0;
      max_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      items_r     <= items_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

### sv/cs_checker.sv
// ---------------------------------------------------------------------------
// Counting sorter checker
// Port level assertions on the sorter, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input cs_pkg::out_t out_data
);

  // The histogram clearing pass keeps the input closed right after reset.
  `CS_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> in_stall, "input open during clearing")

  // While a result that is not the final one waits, the set is still being emitted.
  `CS_ASSERT(a_busy_while_emitting, clk, rst_n, out_valid && !out_data.last_out |-> in_stall,
    "input open in the middle of an emission")

  // A stalled result transaction holds its payload.
  `CS_ASSERT(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind counting_sorter cs_checker u_cs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Counting sorter testbench
// Loads key sets with random gaps and output stalls, and rewrites the key
// limit between sets. A scoreboard keeps its own histogram, predicts the
// ascending key stream of every set and checks each result transaction.
// ---------------------------------------------------------------------------

localparam int SET_CAPACITY = 64;

class sort_scoreboard;
  bit [6:0] bin_hist [0:255];
  bit [6:0] keys_held;
  bit [7:0] key_limit;
  cs_pkg::out_t sorted_q [$];
  int errors;

  function new();
    foreach (bin_hist[i]) bin_hist[i] = '0;
    keys_held = '0;
    key_limit = 8'hFF;
    errors = 0;
  endfunction

  function void set_limit(bit [7:0] value);
    key_limit = value;
  endfunction

  function int outstanding();
    return sorted_q.size();
  endfunction

  function void note_key(cs_pkg::in_t item);
    bit [7:0] key;
    int total;
    int sent;
    cs_pkg::out_t res;
    key = (item.key_value > key_limit) ? key_limit : item.key_value;
    if (keys_held < SET_CAPACITY) begin
      bin_hist[key] = bin_hist[key] + 7'd1;
      keys_held = keys_held + 7'd1;
    end
    if (item.is_last) begin
      total = keys_held;
      sent = 0;
      for (int b = 0; b < 256; b++) begin
        for (int n = 0; n < bin_hist[b]; n++) begin
          if (sent < SET_CAPACITY) begin
            sent++;
            res.sorted_value = b[7:0];
            res.last_out = (sent == total);
            sorted_q.push_back(res);
          end
        end
        bin_hist[b] = '0;
      end
      keys_held = '0;
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_sorted(cs_pkg::out_t got);
    cs_pkg::out_t want;
    if (sorted_q.size() == 0) begin
      report($sformatf("key %0d last %0d arrived with nothing expected",
                       got.sorted_value, got.last_out));
    end else begin
      want = sorted_q.pop_front();
      if (got.sorted_value !== want.sorted_value)
        report($sformatf("sorted_value %0d, expected %0d",
                         got.sorted_value, want.sorted_value));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %0d, expected %0d on key %0d",
                         got.last_out, want.last_out, want.sorted_value));
    end
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 600;
  localparam int RANDOM_ITEMS   = 310;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cs_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  cs_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [cs_pkg::KEY_W-1:0] cfg_data;

  sort_scoreboard sb;
  int rx_hold = 0;
  bit rx_quiet = 1'b0;
  int idle_cycles = 0;

  counting_sorter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_key(in_data);
      if (out_valid && !out_stall) begin
        sb.check_sorted(out_data);
        if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 13);
      end
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task send_key(bit [7:0] key, bit last, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.key_value <= key;
    in_data.is_last <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task run_set(int len, int style, bit quiet);
    bit [7:0] key;
    bit [7:0] base;
    base = 8'($urandom_range(0, 248));
    for (int i = 0; i < len; i++) begin
      case (style)
        1: key = 8'(base + $urandom_range(0, 7));
        2: begin
          case ($urandom_range(0, 3))
            0: key = 8'h00;
            1: key = 8'hFF;
            2: key = 8'h01;
            default: key = 8'hFE;
          endcase
        end
        default: key = 8'($urandom_range(0, 255));
      endcase
      send_key(key, i == len - 1, quiet);
    end
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task write_limit(bit [7:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int items;
    int phase_items;
    int len;
    int style;
    bit [7:0] lim;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sets: extremes, duplicates, a single key, descending keys.
    send_key(8'd0, 1'b0, 1'b0);
    send_key(8'd255, 1'b0, 1'b0);
    send_key(8'd128, 1'b0, 1'b1);
    send_key(8'd0, 1'b0, 1'b1);
    send_key(8'd255, 1'b1, 1'b0);
    send_key(8'd42, 1'b1, 1'b0);
    send_key(8'd200, 1'b0, 1'b1);
    send_key(8'd150, 1'b0, 1'b1);
    send_key(8'd100, 1'b0, 1'b1);
    send_key(8'd50, 1'b0, 1'b1);
    send_key(8'd1, 1'b1, 1'b1);

    // Keys above the limit are clamped to it.
    write_limit(8'd100);
    send_key(8'd99, 1'b0, 1'b0);
    send_key(8'd100, 1'b0, 1'b0);
    send_key(8'd101, 1'b0, 1'b1);
    send_key(8'd255, 1'b0, 1'b0);
    send_key(8'd0, 1'b1, 1'b0);
    write_limit(8'd0);
    send_key(8'd0, 1'b0, 1'b0);
    send_key(8'd255, 1'b0, 1'b0);
    send_key(8'd17, 1'b1, 1'b0);

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      case (phase % 5)
        0: lim = 8'hFF;
        1: lim = 8'($urandom_range(0, 255));
        2: lim = 8'd1;
        3: lim = 8'hFE;
        default: lim = 8'($urandom_range(16, 255));
      endcase
      write_limit(lim);
      phase_items = 0;
      if (phase == 0) begin
        // Full set whose last transaction is dropped but still starts the output.
        run_set(SET_CAPACITY + 1, 0, 1'b0);
        phase_items += SET_CAPACITY + 1;
      end
      while (phase_items < 55) begin
        if ($urandom_range(0, 19) == 0)
          len = $urandom_range(SET_CAPACITY, SET_CAPACITY + 6);
        else if ($urandom_range(0, 3) == 0)
          len = 1;
        else
          len = $urandom_range(2, 16);
        style = $urandom_range(0, 3);
        if (style == 3) style = 0;
        run_set(len, style, $urandom_range(0, 3) == 0);
        phase_items += len;
      end
      items += phase_items;
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

### counting_sorter.f
+incdir+sv
sv/cs_pkg.sv
sv/counting_sorter.sv
sv/cs_checker.sv
sim/tb.sv
